// File: rtl/core/pba_pkg.sv
// ----------------------------------------------------------------------------
// pba_pkg
// Shared types, constants and bit helpers for the page bitmap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package pba_pkg;

	localparam int MAX_PAGES   = 65536;
	localparam int WORD_BITS   = 64;
	localparam int MAP_WORDS   = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
	localparam int WORD_AW     = $clog2(MAP_WORDS);
	localparam int PAGE_W      = 17;
	localparam int IDX_W       = 16;
	localparam int CNT_W       = 17;
	localparam int BIT_W       = 6;
	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
	localparam logic [PAGE_W-1:0] MAX_PAGES_C = PAGE_W'(MAX_PAGES);

	typedef enum logic [2:0] {
		CMD_ALLOC_ONE = 3'd0,
		CMD_ALLOC_RUN = 3'd1,
		CMD_FREE      = 3'd2,
		CMD_LOCK      = 3'd3,
		CMD_RESERVE   = 3'd4,
		CMD_UNRESERVE = 3'd5
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLR,
		ST_SC_RD,
		ST_SC_EX,
		ST_SW_RD,
		ST_SW_EX
	} state_t;

	// index of lowest set bit, WORD_BITS when none is set
	function automatic logic [BIT_W:0] ffs64(input logic [WORD_BITS-1:0] v);
		logic [BIT_W:0] r;
		r = (BIT_W+1)'(WORD_BITS);
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (v[i]) r = (BIT_W+1)'(i);
		end
		return r;
	endfunction

	function automatic logic [BIT_W:0] pop64(input logic [WORD_BITS-1:0] v);
		logic [BIT_W:0] r;
		r = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			r = r + (BIT_W+1)'(v[i]);
		end
		return r;
	endfunction

	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] x,
		input logic [BIT_W:0] n);
		logic [CNT_W:0] s;
		s = {1'b0, x} + (CNT_W+1)'(n);
		return s[CNT_W] ? COUNT_MAX : s[CNT_W-1:0];
	endfunction

	function automatic logic [CNT_W-1:0] sat_sub(input logic [CNT_W-1:0] x,
		input logic [BIT_W:0] n);
		return (x > CNT_W'(n)) ? x - CNT_W'(n) : '0;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/pba_map_ram.sv
// ----------------------------------------------------------------------------
// pba_map_ram
// Busy bitmap store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pba_map_ram
	import pba_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [WORD_AW-1:0]   waddr,
	input  wire logic [WORD_BITS-1:0] wdata,
	input  wire logic                 re,
	input  wire logic [WORD_AW-1:0]   raddr,
	output logic      [WORD_BITS-1:0] rdata
);

	logic [WORD_BITS-1:0] mem [MAP_WORDS];

	// write port
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
	end

	// read port, data holds while re is low
	always_ff @(posedge clk) begin
		if (re) rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// File: rtl/core/page_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// page_bitmap_allocator
// Bitmap page frame allocator: single and run allocation, span updates.
// ----------------------------------------------------------------------------
// done strobes in the cycle after the last step; a command that touches
// no page answers in the cycle after its transfer. A search reads each map
// word and examines it, once more per busy page met below its top bit; a
// span or a found run reads and then writes each word it covers. One command
// at a time is taken. Reset and every total_pages write clear all map words
// with busy high; the receiver cannot stall.
`default_nettype none

module page_bitmap_allocator
	import pba_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [2:0]        cmd,
	input  wire logic [IDX_W-1:0]  page_index,
	input  wire logic [CNT_W-1:0]  req_count,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [CNT_W-1:0]  cfg_data,
	output logic                   done,
	output logic [IDX_W-1:0]       start_page,
	output logic                   found,
	output logic [CNT_W-1:0]       pages_free,
	output logic [CNT_W-1:0]       used_pages,
	output logic [CNT_W-1:0]       reserved_pages
);

	state_t state_q, state_d;

	logic [CNT_W-1:0]   total_q;
	logic [PAGE_W-1:0]  hint_q, pos_q, s_q;
	logic [CNT_W-1:0]   cnt_q, run_q;
	logic [PAGE_W:0]    lo_q, hi_q;
	logic               mark_q, kind_q, one_q;
	logic [WORD_AW-1:0] clr_q;
	logic [CNT_W-1:0]   free_q, used_q, resv_q;
	logic               done_q, found_q;
	logic [IDX_W-1:0]   start_q;

	logic [PAGE_W-1:0]    lim;
	logic                 mem_we, mem_re;
	logic [WORD_AW-1:0]   mem_waddr, mem_raddr;
	logic [WORD_BITS-1:0] mem_wdata, rdata;

	assign lim = (total_q > MAX_PAGES_C) ? MAX_PAGES_C : total_q;

	pba_map_ram u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (rdata)
	);

	// command decode at accept
	logic             acc;
	logic             is_span;
	logic [PAGE_W:0]  sp_end, sp_hi;
	assign acc     = start && !busy;
	assign is_span = cmd inside {[CMD_FREE:CMD_UNRESERVE]};
	assign sp_end  = (PAGE_W+1)'(page_index) + (PAGE_W+1)'(req_count);
	assign sp_hi   = (sp_end > (PAGE_W+1)'(lim)) ? (PAGE_W+1)'(lim) : sp_end;

	// search step over the current word
	logic [PAGE_W-1:0]    wb, lim_off;
	logic [WORD_BITS-1:0] lim_mask, bm;
	logic [BIT_W:0]       q7, f;
	logic [PAGE_W:0]      run_tot, run_end;
	logic                 sc_hit, sc_out;
	logic [BIT_W-1:0]     b;

	always_comb begin
		wb       = {pos_q[PAGE_W-1:BIT_W], {BIT_W{1'b0}}};
		b        = pos_q[BIT_W-1:0];
		lim_off  = lim - wb;
		lim_mask = (lim_off >= PAGE_W'(WORD_BITS)) ? '0 :
			~((WORD_BITS'(1) << lim_off[BIT_W-1:0]) - WORD_BITS'(1));
		bm       = (rdata | lim_mask) & ({WORD_BITS{1'b1}} << b);
		q7       = ffs64(bm);
		f        = q7 - (BIT_W+1)'(b);
		run_tot  = (PAGE_W+1)'(run_q) + (PAGE_W+1)'(f);
		sc_hit   = run_tot >= (PAGE_W+1)'(cnt_q);
		run_end  = (PAGE_W+1)'(pos_q) + (PAGE_W+1)'(cnt_q - run_q) - (PAGE_W+1)'(1);
		sc_out   = pos_q >= lim;
	end

	// span step over the current word
	logic [PAGE_W:0]      lo_d, hi_d;
	logic [BIT_W:0]       lo_off, hi_off;
	logic [WORD_BITS-1:0] sp_mask, chg;
	logic [BIT_W:0]       n_chg, low7;
	logic [PAGE_W-1:0]    low_pg;
	logic [PAGE_W:0]      next_wb;

	always_comb begin
		lo_d    = lo_q - (PAGE_W+1)'(wb);
		hi_d    = hi_q - (PAGE_W+1)'(wb);
		lo_off  = (lo_q > (PAGE_W+1)'(wb)) ? lo_d[BIT_W:0] : '0;
		hi_off  = (hi_d >= (PAGE_W+1)'(WORD_BITS)) ? (BIT_W+1)'(WORD_BITS) : hi_d[BIT_W:0];
		for (int i = 0; i < WORD_BITS; i++) begin
			sp_mask[i] = ((BIT_W+1)'(i) >= lo_off) && ((BIT_W+1)'(i) < hi_off);
		end
		chg     = sp_mask & (mark_q ? ~rdata : rdata);
		n_chg   = pop64(chg);
		low7    = ffs64(chg);
		low_pg  = wb + PAGE_W'(low7[BIT_W-1:0]);
		next_wb = (PAGE_W+1)'(wb) + (PAGE_W+1)'(WORD_BITS);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					if (cmd == CMD_ALLOC_ONE ||
						(cmd == CMD_ALLOC_RUN && req_count != '0))
						state_d = ST_SC_RD;
					else if (is_span && sp_hi > (PAGE_W+1)'(page_index))
						state_d = ST_SW_RD;
				end
			end
			ST_CLR:   if (clr_q == {WORD_AW{1'b1}}) state_d = ST_IDLE;
			ST_SC_RD: state_d = sc_out ? ST_IDLE : ST_SC_EX;
			ST_SC_EX: begin
				if (sc_out) state_d = ST_IDLE;
				else if (sc_hit) state_d = ST_SW_RD;
				else if (q7[BIT_W] || q7 == (BIT_W+1)'(WORD_BITS - 1)) state_d = ST_SC_RD;
			end
			ST_SW_RD: state_d = ST_SW_EX;
			ST_SW_EX: state_d = (next_wb >= hi_q) ? ST_IDLE : ST_SW_RD;
			default:  state_d = ST_IDLE;
		endcase
		if (cfg_valid) state_d = ST_CLR;
	end

	// memory controls
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = pos_q[IDX_W-1:BIT_W];
		mem_wdata = rdata ^ chg;
		mem_re    = 1'b0;
		mem_raddr = pos_q[IDX_W-1:BIT_W];
		case (state_q)
			ST_CLR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			ST_SC_RD: mem_re = !sc_out;
			ST_SW_RD: mem_re = 1'b1;
			ST_SW_EX: mem_we = 1'b1;
			default: ;
		endcase
	end

	// datapath and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			total_q <= CNT_W'(MAX_PAGES);
			hint_q  <= '0;
			free_q  <= MAX_PAGES_C;
			used_q  <= '0;
			resv_q  <= '0;
			clr_q   <= '0;
			done_q  <= 1'b0;
			found_q <= 1'b0;
			start_q <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			case (state_q)
				ST_IDLE: if (acc) begin
					found_q <= 1'b0;
					start_q <= '0;
					one_q   <= (cmd == CMD_ALLOC_ONE);
					cnt_q   <= (cmd == CMD_ALLOC_ONE) ? CNT_W'(1) : req_count;
					run_q   <= '0;
					pos_q   <= is_span ? PAGE_W'(page_index) : hint_q;
					s_q     <= hint_q;
					lo_q    <= (PAGE_W+1)'(page_index);
					hi_q    <= sp_hi;
					mark_q  <= (cmd == CMD_LOCK || cmd == CMD_RESERVE);
					kind_q  <= (cmd == CMD_RESERVE || cmd == CMD_UNRESERVE);
					if (state_d == ST_IDLE) done_q <= 1'b1;
				end
				ST_CLR: clr_q <= clr_q + WORD_AW'(1);
				ST_SC_RD: if (sc_out) begin
					if (one_q) hint_q <= lim;
					done_q <= 1'b1;
				end
				ST_SC_EX: begin
					if (sc_out) begin
						if (one_q) hint_q <= lim;
						done_q <= 1'b1;
					end else if (sc_hit) begin
						// found: mark s..end as locked
						hint_q  <= run_end[PAGE_W-1:0];
						found_q <= 1'b1;
						start_q <= s_q[IDX_W-1:0];
						lo_q    <= (PAGE_W+1)'(s_q);
						hi_q    <= run_end + (PAGE_W+1)'(1);
						pos_q   <= s_q;
						mark_q  <= 1'b1;
						kind_q  <= 1'b0;
					end else if (q7[BIT_W]) begin
						run_q <= run_tot[CNT_W-1:0];
						pos_q <= next_wb[PAGE_W-1:0];
					end else begin
						// busy page: restart the run after it
						run_q <= '0;
						s_q   <= wb + PAGE_W'(q7) + PAGE_W'(1);
						pos_q <= wb + PAGE_W'(q7) + PAGE_W'(1);
					end
				end
				ST_SW_EX: begin
					if (mark_q) begin
						free_q <= sat_sub(free_q, n_chg);
						if (kind_q) resv_q <= sat_add(resv_q, n_chg);
						else used_q <= sat_add(used_q, n_chg);
					end else begin
						free_q <= sat_add(free_q, n_chg);
						if (kind_q) resv_q <= sat_sub(resv_q, n_chg);
						else used_q <= sat_sub(used_q, n_chg);
						if (!low7[BIT_W] && hint_q > low_pg) hint_q <= low_pg;
					end
					pos_q <= next_wb[PAGE_W-1:0];
					if (next_wb >= hi_q) done_q <= 1'b1;
				end
				default: ;
			endcase
			// register write restarts the allocator
			if (cfg_valid) begin
				total_q <= cfg_data;
				hint_q  <= '0;
				free_q  <= (cfg_data > MAX_PAGES_C) ? MAX_PAGES_C : cfg_data;
				used_q  <= '0;
				resv_q  <= '0;
				clr_q   <= '0;
			end
		end
	end

	assign busy           = (state_q != ST_IDLE);
	assign cfg_ready      = 1'b1;
	assign done           = done_q;
	assign start_page     = start_q;
	assign found          = found_q;
	assign pages_free     = free_q;
	assign used_pages     = used_q;
	assign reserved_pages = resv_q;

endmodule

`default_nettype wire
